### hw/rtl/ppa_pkg.sv
// Shared types and constants for the physical page allocator.
package ppa_pkg;
	localparam int PAGE_SHIFT = 12;

	localparam logic [2:0] FUNC_ALLOC_LOW   = 3'd0;
	localparam logic [2:0] FUNC_ALLOC_HIGH  = 3'd1;
	localparam logic [2:0] FUNC_FREE_PAGE   = 3'd2;
	localparam logic [2:0] FUNC_ALLOC_RANGE = 3'd3;
	localparam logic [2:0] FUNC_FREE_RANGE  = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_PAGE = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	typedef struct packed {
		logic [31:0] byte_length;
		logic [31:0] byte_address;
		logic [2:0]  func;
	} req_t;

	typedef struct packed {
		logic [16:0] free_count;
		logic [16:0] used_count;
		logic [1:0]  status;
		logic [31:0] result_address;
	} rsp_t;
endpackage

### hw/rtl/ppa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module ppa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/physical_page_allocator_unit.sv
// Top level of the physical page allocator.
// One request at a time. The used map lives in a RAM of 32-bit words; work on a
// word goes through a read state and a modify/write state. A request visits the
// map words it touches in turn (an allocation stops at the first free page), and
// S_OUT then loads its result. A rejected page or range, an empty range or an
// unused code goes straight to S_OUT. After reset and after each page_count
// write, a setup pass writes every map word to all ones (MAX_PAGES/32 words,
// rounded up, one per cycle) while no request is taken. A result waits in an
// output register; the next request can be taken the cycle after the result is
// loaded, and its own result waits until the previous one has been transferred.
// A pending page_count write holds off requests and is taken only once no
// result is waiting.
module physical_page_allocator_unit #(
	parameter int MAX_PAGES         = 65536,
	parameter int LOW_REGION_PAGES  = 256,
	parameter int HIGH_REGION_START = 272
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [16:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,   // func[2:0], byte_address[34:3], byte_length[66:35], zeros
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata    // result_address, status, used_count, free_count, zeros
);
	import ppa_pkg::*;

	localparam int WORDS     = (MAX_PAGES + 31) / 32;
	localparam int WAW       = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int WCW       = WAW + 1;
	localparam int LOW_WORDS = ((LOW_REGION_PAGES + 31) / 32 > WORDS) ? WORDS
		: (LOW_REGION_PAGES + 31) / 32;
	localparam logic [16:0] MAXP17 = (MAX_PAGES > 65536) ? 17'h1ffff : 17'(MAX_PAGES);

	localparam logic [2:0] S_INIT = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_MOD = 3'd3,
		S_OUT = 3'd4;

	logic [2:0]  state_q;
	logic [16:0] page_count_q;
	logic [16:0] used_q;
	logic [WCW-1:0] widx_q;
	logic [WCW-1:0] wend_q;
	logic [2:0]  func_q;
	logic [32:0] first_q, endp_q;  // page bounds (first inclusive, end exclusive)
	logic [1:0]  status_q;
	logic [31:0] res_q;
	logic        outv_q;
	rsp_t        rsp_q;

	logic        we;
	logic [WAW-1:0] waddr, raddr;
	logic [31:0] wdata, rdata;

	ppa_ram #(.WIDTH(32), .DEPTH(WORDS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	req_t req;
	assign req = s_tdata[66:0];

	logic [32:0] sum, rend, first_pg;
	logic [33:0] sum_up;
	logic [27:0] rend_w;
	logic [12:0] pc_w;
	assign sum      = {1'b0, req.byte_address} + {1'b0, req.byte_length};
	assign sum_up   = {1'b0, sum} + 34'hfff;
	assign rend     = (req.func == FUNC_ALLOC_RANGE) ? 33'(sum_up >> PAGE_SHIFT)
		: (sum >> PAGE_SHIFT);
	assign first_pg = {13'd0, req.byte_address[31:12]};
	assign rend_w   = rend[32:5] + 28'(|rend[4:0]);
	assign pc_w     = {1'b0, page_count_q[16:5]} + 13'(|page_count_q[4:0]);

	// per-word mask of pages in [first_q, endp_q) and below page_count
	logic [31:0] inmask;
	logic [32:0] lim;
	assign lim = (endp_q < {16'd0, page_count_q}) ? endp_q : {16'd0, page_count_q};
	always_comb begin
		logic [32:0] p;
		for (int b = 0; b < 32; b++) begin
			p = 33'({widx_q, 5'd0}) + 33'(b);
			inmask[b] = (p >= first_q) && (p < lim);
		end
	end

	logic        is_alloc;
	logic [31:0] setbits, cand;
	logic [4:0]  fbit;
	logic        found;
	assign is_alloc = (func_q == FUNC_ALLOC_LOW) || (func_q == FUNC_ALLOC_HIGH);
	assign cand = ~rdata & inmask;
	always_comb begin
		found = 1'b0;
		fbit  = 5'd0;
		for (int b = 31; b >= 0; b--) begin
			if (cand[b]) begin
				found = 1'b1;
				fbit  = 5'(b);
			end
		end
	end

	logic [31:0] newword;
	logic [5:0]  delta;
	always_comb begin
		setbits = '0;
		if (is_alloc) begin
			if (found) setbits[fbit] = 1'b1;
			newword = rdata | setbits;
			delta = 6'(found);
		end else if (func_q == FUNC_ALLOC_RANGE) begin
			newword = rdata | inmask;
			delta = 6'($countones(~rdata & inmask));
		end else begin
			newword = rdata & ~inmask;
			delta = 6'($countones(rdata & inmask));
		end
	end

	logic last_word;
	assign last_word = (widx_q + 1'b1 >= wend_q);

	assign cfg_ready = (state_q == S_IDLE) && !outv_q;
	assign s_tready  = (state_q == S_IDLE) && !cfg_valid;
	assign we    = (state_q == S_INIT) || (state_q == S_MOD);
	assign waddr = widx_q[WAW-1:0];
	assign wdata = (state_q == S_INIT) ? '1 : newword;
	assign raddr = widx_q[WAW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			page_count_q <= MAXP17;
			used_q       <= MAXP17;
			widx_q       <= '0;
			wend_q       <= '0;
			func_q       <= '0;
			first_q      <= '0;
			endp_q       <= '0;
			status_q     <= ST_OK;
			res_q        <= '0;
			rsp_q        <= '0;
			outv_q       <= 1'b0;
		end else begin
			if (outv_q && m_tready) outv_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					widx_q <= widx_q + 1'b1;
					if (widx_q == WCW'(WORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						page_count_q <= (cfg_data > MAXP17) ? MAXP17 : cfg_data;
						used_q       <= (cfg_data > MAXP17) ? MAXP17 : cfg_data;
						widx_q       <= '0;
						state_q      <= S_INIT;
					end else if (s_tvalid && s_tready) begin
						func_q <= req.func;
						case (req.func)
							FUNC_ALLOC_LOW: begin
								first_q  <= '0;
								endp_q   <= 33'(LOW_REGION_PAGES);
								res_q    <= '0;
								status_q <= ST_NO_PAGE;
								widx_q   <= '0;
								wend_q   <= WCW'(LOW_WORDS);
								state_q  <= S_RD;
							end
							FUNC_ALLOC_HIGH: begin
								first_q  <= 33'(HIGH_REGION_START);
								endp_q   <= {16'd0, page_count_q};
								res_q    <= '0;
								status_q <= ST_NO_PAGE;
								widx_q   <= WCW'(HIGH_REGION_START / 32);
								wend_q   <= WCW'(pc_w);
								state_q  <= S_RD;
							end
							FUNC_FREE_PAGE: begin
								first_q <= first_pg;
								endp_q  <= first_pg + 33'd1;
								res_q   <= '0;
								widx_q  <= WCW'(req.byte_address[31:17]);
								wend_q  <= WCW'(req.byte_address[31:17]) + 1'b1;
								if (first_pg >= {16'd0, page_count_q}) begin
									status_q <= ST_RANGE;
									state_q  <= S_OUT;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_RD;
								end
							end
							FUNC_ALLOC_RANGE, FUNC_FREE_RANGE: begin
								first_q <= first_pg;
								endp_q  <= rend;
								widx_q  <= WCW'(req.byte_address[31:17]);
								wend_q  <= WCW'(rend_w);
								if (rend > {16'd0, page_count_q}) begin
									status_q <= ST_RANGE;
									res_q    <= '0;
									state_q  <= S_OUT;
								end else begin
									status_q <= ST_OK;
									res_q    <= req.byte_address;
									state_q  <= (first_pg < rend) ? S_RD : S_OUT;
								end
							end
							default: begin
								res_q    <= '0;
								status_q <= ST_OK;
								state_q  <= S_OUT;
							end
						endcase
					end
				end
				S_RD: state_q <= (widx_q >= wend_q || widx_q >= WCW'(WORDS)) ? S_OUT : S_MOD;
				S_MOD: begin
					if (is_alloc) begin
						if (found) begin
							used_q   <= used_q + 17'd1;
							res_q    <= 32'({widx_q[WAW-1:0], fbit}) << PAGE_SHIFT;
							status_q <= ST_OK;
						end
					end else if (func_q == FUNC_ALLOC_RANGE) begin
						used_q <= used_q + 17'(delta);
					end else begin
						used_q <= used_q - 17'(delta);
					end
					widx_q <= widx_q + 1'b1;
					state_q <= (last_word || (is_alloc && found)) ? S_OUT : S_RD;
				end
				S_OUT: begin
					if (!outv_q) begin
						rsp_q.result_address <= res_q;
						rsp_q.status         <= status_q;
						rsp_q.used_count     <= used_q;
						rsp_q.free_count     <= page_count_q - used_q;
						outv_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = outv_q;
	assign m_tdata  = {4'd0, rsp_q};
endmodule

### hw/rtl/ppa_checker.sv
// Port-level checker for the physical page allocator, bound to the top level.
module ppa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("request taken while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[33:32] != 2'd3) else $error("bad status");
	a_one_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid) else $error("result repeated");
endmodule

bind physical_page_allocator_unit ppa_checker u_ppa_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
